// File: rtl/tuart_pkg.sv
// Package: shared types and constants of the tick-driven 8N1 UART transceiver.
package tuart_pkg;

    localparam int BitPeriodW   = 16;
    localparam int HalfPeriodW  = 15;
    localparam int RxCountW     = 17;
    localparam int TxCountW     = 16;
    localparam int BitsLeftW    = 4;
    localparam int FrameW       = 10;
    localparam int CfgIndexW    = 1;
    localparam int CfgDataW     = 16;

    localparam logic [BitPeriodW-1:0]  BitPeriodReset  = 16'd104;
    localparam logic [HalfPeriodW-1:0] HalfPeriodReset = 15'd52;
    localparam logic [BitsLeftW-1:0]   FrameBits       = 4'd10;
    localparam logic [BitsLeftW-1:0]   DataBits        = 4'd8;

    // Item command codes.
    localparam logic CmdTick = 1'b0;
    localparam logic CmdLoad = 1'b1;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_BIT_PERIOD      = 1'b0,
        CFG_HALF_BIT_PERIOD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] tx_byte;
        logic       rx_line;
    } in_item_t;

    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       load_refused;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } out_item_t;

endpackage

// File: rtl/tuart_if.sv
// Interfaces: valid/ready channels for items, results and register writes.
interface tuart_in_if;
    logic                valid;
    logic                ready;
    tuart_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tuart_out_if;
    logic                 valid;
    logic                 ready;
    tuart_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tuart_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [tuart_pkg::CfgIndexW-1:0]       index;
    logic [tuart_pkg::CfgDataW-1:0]        wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/timer_uart_8n1_transceiver_unit.sv
// Top level: tick-driven 8N1 UART transmitter and receiver sharing one timer tick.
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle; the only stall is a full output register whose
// result is not taken, which holds off the next item until it drains.
// Reset: rst_n clears all control state at once, loads bit_period 104 and
// half_bit_period 52, and leaves both lines idle high; no clearing pass is needed.
module timer_uart_8n1_transceiver_unit (
    input logic        clk,
    input logic        rst_n,
    tuart_in_if.sink   cmd_ch,
    tuart_out_if.source result_ch,
    tuart_cfg_if.sink  cfg_ch
);
    import tuart_pkg::*;

    // Configuration registers
    logic [BitPeriodW-1:0]  bit_period_reg;
    logic [HalfPeriodW-1:0] half_bit_period_reg;

    // Transmitter state
    logic [FrameW-1:0]    tx_frame_reg,      tx_frame_next;
    logic [BitsLeftW-1:0] tx_bits_left_reg,  tx_bits_left_next;
    logic [TxCountW-1:0]  tx_tick_count_reg, tx_tick_count_next;
    logic                 tx_active_reg,     tx_active_next;
    logic                 tx_level_reg,      tx_level_next;

    // Receiver state
    logic                 rx_hunting_reg,    rx_hunting_next;
    logic                 rx_prev_level_reg, rx_prev_level_next;
    logic [RxCountW-1:0]  rx_tick_count_reg, rx_tick_count_next;
    logic [BitsLeftW-1:0] rx_bits_left_reg,  rx_bits_left_next;
    logic [7:0]           rx_shift_reg,      rx_shift_next;
    logic [7:0]           rx_last_byte_reg,  rx_last_byte_next;

    // Output register
    logic      out_valid_reg;
    out_item_t out_data_reg, out_data_next;

    logic      in_accept;
    logic      is_tick;
    logic      refused;
    logic      rx_done;
    logic [RxCountW-1:0] tx_count_inc;
    logic [RxCountW-1:0] rx_start_count;
    logic [7:0]          rx_shift_shifted;

    // Take a new item whenever the output register is empty or drains this cycle.
    assign cmd_ch.ready    = !out_valid_reg || result_ch.ready;
    assign in_accept       = cmd_ch.valid && cmd_ch.ready;
    assign is_tick         = (cmd_ch.data.cmd == CmdTick);

    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_data_reg;

    // Register writes are always taken.
    assign cfg_ch.ready = 1'b1;

    assign tx_count_inc     = {1'b0, tx_tick_count_reg} + RxCountW'(1);
    assign rx_start_count   = RxCountW'(bit_period_reg) + RxCountW'(half_bit_period_reg);
    assign rx_shift_shifted = {cmd_ch.data.rx_line, rx_shift_reg[7:1]};

    always_comb
    begin
        tx_frame_next      = tx_frame_reg;
        tx_bits_left_next  = tx_bits_left_reg;
        tx_tick_count_next = tx_tick_count_reg;
        tx_active_next     = tx_active_reg;
        tx_level_next      = tx_level_reg;
        rx_hunting_next    = rx_hunting_reg;
        rx_prev_level_next = rx_prev_level_reg;
        rx_tick_count_next = rx_tick_count_reg;
        rx_bits_left_next  = rx_bits_left_reg;
        rx_shift_next      = rx_shift_reg;
        rx_last_byte_next  = rx_last_byte_reg;
        refused            = 1'b0;
        rx_done            = 1'b0;

        if (!is_tick)
        begin
            // Load: drop it if a frame is still running, else arm a fresh frame
            // of start bit, data LSB first, stop bit.
            if (tx_active_reg)
            begin
                refused = 1'b1;
            end
            else
            begin
                tx_frame_next      = {1'b1, cmd_ch.data.tx_byte, 1'b0};
                tx_bits_left_next  = FrameBits;
                tx_tick_count_next = '0;
                tx_active_next     = 1'b1;
            end
        end
        else
        begin
            // Transmit half: advance one tick, act on a bit boundary.
            if (tx_active_reg)
            begin
                if (tx_count_inc < {1'b0, bit_period_reg})
                begin
                    tx_tick_count_next = tx_count_inc[TxCountW-1:0];
                end
                else
                begin
                    tx_tick_count_next = '0;
                    if (tx_bits_left_reg == '0)
                    begin
                        // Trailing period over: release the transmitter.
                        tx_active_next    = 1'b0;
                        tx_bits_left_next = FrameBits;
                    end
                    else
                    begin
                        tx_level_next     = tx_frame_reg[0];
                        tx_frame_next     = {1'b0, tx_frame_reg[FrameW-1:1]};
                        tx_bits_left_next = tx_bits_left_reg - BitsLeftW'(1);
                    end
                end
            end

            // Receive half: hunt for a falling edge, then sample on countdown.
            if (rx_hunting_reg)
            begin
                if (rx_prev_level_reg && !cmd_ch.data.rx_line)
                begin
                    rx_hunting_next    = 1'b0;
                    rx_tick_count_next = rx_start_count;
                end
            end
            else if (rx_tick_count_reg <= RxCountW'(1))
            begin
                rx_tick_count_next = RxCountW'(bit_period_reg);
                rx_shift_next      = rx_shift_shifted;
                rx_bits_left_next  = rx_bits_left_reg - BitsLeftW'(1);
                if (rx_bits_left_reg == BitsLeftW'(1))
                begin
                    // Eighth sample: publish the byte, skip the stop bit.
                    rx_last_byte_next = rx_shift_shifted;
                    rx_bits_left_next = DataBits;
                    rx_hunting_next   = 1'b1;
                    rx_done           = 1'b1;
                end
            end
            else
            begin
                rx_tick_count_next = rx_tick_count_reg - RxCountW'(1);
            end
            rx_prev_level_next = cmd_ch.data.rx_line;
        end

        out_data_next.tx_line      = tx_level_next;
        out_data_next.tx_busy      = tx_active_next;
        out_data_next.load_refused = refused;
        out_data_next.rx_valid     = rx_done;
        out_data_next.rx_byte      = rx_last_byte_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg      <= BitPeriodReset;
            half_bit_period_reg <= HalfPeriodReset;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (cfg_index_t'(cfg_ch.index))
                CFG_BIT_PERIOD:      bit_period_reg      <= cfg_ch.wdata;
                CFG_HALF_BIT_PERIOD: half_bit_period_reg <= cfg_ch.wdata[HalfPeriodW-1:0];
                default:             bit_period_reg      <= bit_period_reg;
            endcase
        end
    end

    // Transceiver state: advance only on an accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_frame_reg      <= '0;
            tx_bits_left_reg  <= FrameBits;
            tx_tick_count_reg <= '0;
            tx_active_reg     <= 1'b0;
            tx_level_reg      <= 1'b1;
            rx_hunting_reg    <= 1'b1;
            rx_prev_level_reg <= 1'b1;
            rx_tick_count_reg <= '0;
            rx_bits_left_reg  <= DataBits;
            rx_shift_reg      <= '0;
            rx_last_byte_reg  <= '0;
        end
        else if (in_accept)
        begin
            tx_frame_reg      <= tx_frame_next;
            tx_bits_left_reg  <= tx_bits_left_next;
            tx_tick_count_reg <= tx_tick_count_next;
            tx_active_reg     <= tx_active_next;
            tx_level_reg      <= tx_level_next;
            rx_hunting_reg    <= rx_hunting_next;
            rx_prev_level_reg <= rx_prev_level_next;
            rx_tick_count_reg <= rx_tick_count_next;
            rx_bits_left_reg  <= rx_bits_left_next;
            rx_shift_reg      <= rx_shift_next;
            rx_last_byte_reg  <= rx_last_byte_next;
        end
    end

    // Output register: fill on accept, drop when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // An accepted item always leaves a result behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    // A load that meets a running frame must come back refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !is_tick && tx_active_reg) |=> out_data_reg.load_refused)
        else $error("load during busy transmitter was not refused");

    // An idle transmitter always sits armed for a full frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        !tx_active_reg |-> (tx_bits_left_reg == FrameBits))
        else $error("idle transmitter holds a partial bit count");

    // The receive bit counter never leaves the range one to eight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx_bits_left_reg != '0) && (rx_bits_left_reg <= DataBits))
        else $error("receive bit counter out of range");

endmodule

// File: test/testbench.sv
// Testbench for the tick-driven 8N1 UART transceiver: stimulus, prediction and result checks.
`timescale 1ns / 1ps

module testbench;
    import tuart_pkg::*;

    localparam int CycleLimit = 1_000_000;
    localparam int NumPhases  = 8;

    // Timing settings for the random phases. Index 0 starts at the slowest legal bit
    // rate's opposite end (shortest bits). The last phase uses the longest bit and
    // receive delay; it runs last because its receive countdown outlasts the run.
    int unsigned phase_period [NumPhases] = '{4, 5, 8, 13, 6, 7, 10, 65535};
    int unsigned phase_half   [NumPhases] = '{2, 3, 4, 2, 9, 3, 5, 32767};
    int unsigned phase_items  [NumPhases] = '{300, 250, 300, 250, 200, 250, 200, 40};
    bit          phase_calm   [NumPhases] = '{0, 1, 0, 0, 0, 1, 0, 0};

    // Tracks the transceiver state, predicts one result per accepted item and checks
    // the results in order.
    class uart_scoreboard;
        logic [15:0] bit_period;
        logic [14:0] half_period;
        logic [9:0]  tx_frame;
        logic [3:0]  tx_bits_left;
        logic [16:0] tx_ticks;
        logic        tx_active;
        logic        tx_level;
        logic        rx_hunting;
        logic        rx_prev;
        logic [16:0] rx_ticks;
        logic [3:0]  rx_bits_left;
        logic [7:0]  rx_shift;
        logic [7:0]  rx_last;
        out_item_t   expected_q[$];
        int unsigned items_taken;
        int unsigned loads_taken;
        int unsigned loads_refused;
        int unsigned rx_bytes;
        int unsigned checked;
        int unsigned mismatches;

        function new();
            bit_period   = BitPeriodReset;
            half_period  = HalfPeriodReset;
            tx_frame     = '0;
            tx_bits_left = FrameBits;
            tx_ticks     = '0;
            tx_active    = 1'b0;
            tx_level     = 1'b1;
            rx_hunting   = 1'b1;
            rx_prev      = 1'b1;
            rx_ticks     = '0;
            rx_bits_left = DataBits;
            rx_shift     = '0;
            rx_last      = '0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] value);
            case (idx)
                CFG_BIT_PERIOD:      bit_period  = value;
                CFG_HALF_BIT_PERIOD: half_period = value[14:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Advance the model by one accepted item and queue the result it produces.
        function void note_item(in_item_t it);
            out_item_t r;
            r = '0;
            items_taken++;
            if (it.cmd == CmdLoad) begin
                // A load is not a tick: neither half advances.
                if (tx_active) begin
                    r.load_refused = 1'b1;
                    loads_refused++;
                end else begin
                    tx_frame     = {1'b1, it.tx_byte, 1'b0};
                    tx_bits_left = FrameBits;
                    tx_ticks     = '0;
                    tx_active    = 1'b1;
                    loads_taken++;
                end
            end else begin
                if (tx_active) begin
                    tx_ticks = tx_ticks + 17'd1;
                    if (tx_ticks >= {1'b0, bit_period}) begin
                        tx_ticks = '0;
                        if (tx_bits_left == '0) begin
                            tx_active    = 1'b0;
                            tx_bits_left = FrameBits;
                        end else begin
                            tx_level     = tx_frame[0];
                            tx_frame     = tx_frame >> 1;
                            tx_bits_left = tx_bits_left - 4'd1;
                        end
                    end
                end
                if (rx_hunting) begin
                    if (rx_prev && !it.rx_line) begin
                        rx_hunting = 1'b0;
                        rx_ticks   = {1'b0, bit_period} + {2'b00, half_period};
                    end
                end else if (rx_ticks <= 17'd1) begin
                    rx_ticks     = {1'b0, bit_period};
                    rx_shift     = {it.rx_line, rx_shift[7:1]};
                    rx_bits_left = rx_bits_left - 4'd1;
                    if (rx_bits_left == '0) begin
                        rx_last      = rx_shift;
                        rx_bits_left = DataBits;
                        rx_hunting   = 1'b1;
                        r.rx_valid   = 1'b1;
                        rx_bytes++;
                    end
                end else begin
                    rx_ticks = rx_ticks - 17'd1;
                end
                rx_prev = it.rx_line;
            end
            r.tx_line = tx_level;
            r.tx_busy = tx_active;
            r.rx_byte = rx_last;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s of result %0d: expected %0h, got %0h",
                             name, checked, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0h arrived with no item waiting", got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("tx_line", 8'(want.tx_line), 8'(got.tx_line));
            compare_field("tx_busy", 8'(want.tx_busy), 8'(got.tx_busy));
            compare_field("load_refused", 8'(want.load_refused), 8'(got.load_refused));
            compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
            compare_field("rx_byte", want.rx_byte, got.rx_byte);
            checked++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned cycles = 0;
    int unsigned settings_done = 0;
    bit          calm = 1'b0;
    bit          long_hold_done = 1'b0;
    logic        rx_wave[$];

    uart_scoreboard sb = new();

    tuart_in_if  cmd_ch();
    tuart_out_if result_ch();
    tuart_cfg_if cfg_ch();

    timer_uart_8n1_transceiver_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("run timed out after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Idle lengths: mostly none or short, now and then long; none at all in calm phases.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item, idling first for a random gap; valid stays high afterward so
    // back-to-back items keep it asserted without a dip.
    task automatic push_item(input logic cmd, input logic [7:0] byte_val, input logic line);
        in_item_t    it;
        int unsigned gap;
        it.cmd     = cmd;
        it.tx_byte = byte_val;
        it.rx_line = line;
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        do @(posedge clk); while (!cmd_ch.ready);
        sb.note_item(it);
    endtask

    // Drop valid and hold until every predicted result has been checked.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Write both timing registers back to back; valid stays high across the pair.
    task automatic set_timing(input logic [15:0] period, input logic [15:0] half);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_BIT_PERIOD;
        cfg_ch.wdata <= period;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(CFG_BIT_PERIOD, period);
        cfg_ch.index <= CFG_HALF_BIT_PERIOD;
        cfg_ch.wdata <= half;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(CFG_HALF_BIT_PERIOD, half);
        cfg_ch.valid <= 1'b0;
        settings_done++;
    endtask

    // Check every result taken from the block.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.data);
    end

    // Result side: random stalls and runs of ready, plus one long hold-off that lets
    // the output register fill and back-pressure the item channel.
    initial
    begin : result_sink
        int unsigned stall;
        int unsigned run_len;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && sb.items_taken >= 600)
            begin
                long_hold_done = 1'b1;
                stall = 400;
            end
            else
                stall = pick_gap();
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
            repeat (run_len) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int unsigned span;
        logic [7:0]  frame_byte;
        logic        level;

        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_BIT_PERIOD;
        cfg_ch.wdata <= '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset timing: idle tick, a load of all zeros, loads
        // refused while busy, and a start edge that begins a receive countdown.
        push_item(CmdTick, 8'h00, 1'b1);
        push_item(CmdLoad, 8'h00, 1'b1);
        push_item(CmdLoad, 8'hFF, 1'b0);
        push_item(CmdTick, 8'hFF, 1'b0);
        push_item(CmdTick, 8'h00, 1'b0);
        push_item(CmdLoad, 8'hFF, 1'b0);
        settle();

        // Drop to the shortest timing while both halves are mid-frame: the transmitter
        // picks up the new period at once, the receiver keeps its loaded countdown.
        set_timing(16'd4, 16'd2);
        for (int i = 0; i < 16; i++)
            push_item(CmdTick, 8'hA5, i[1]);
        push_item(CmdLoad, 8'h3C, 1'b1);
        settle();

        // Random phases: mostly well-formed receive frames with random bytes at the current
        // bit period or a shorter one, some noise and cut-off frames, and loads mixed in.
        for (int p = 0; p < NumPhases; p++)
        begin
            set_timing(phase_period[p][15:0], phase_half[p][15:0]);
            calm = phase_calm[p];
            rx_wave.delete();
            // Keep the waveform queue small when the bit period is huge.
            span = (phase_period[p] > 16) ? 16 : phase_period[p];
            for (int n = 0; n < phase_items[p]; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_item(CmdLoad, 8'($urandom), 1'($urandom));
                else
                begin
                    if (rx_wave.size() == 0)
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            // Noise: random levels, glitches and broken frames.
                            repeat ($urandom_range(1, 2 * span))
                                rx_wave.push_back(1'($urandom));
                        end
                        else
                        begin
                            frame_byte = 8'($urandom);
                            repeat ($urandom_range(1, 3 * span)) rx_wave.push_back(1'b1);
                            repeat (span) rx_wave.push_back(1'b0);
                            for (int b = 0; b < 8; b++)
                                repeat (span) rx_wave.push_back(frame_byte[b]);
                            repeat (span) rx_wave.push_back(1'b1);
                        end
                    end
                    level = rx_wave.pop_front();
                    push_item(CmdTick, 8'($urandom), level);
                end
            end
            settle();
        end

        calm = 1'b0;
        // Wait out any stray result before the summary.
        repeat (8) @(posedge clk);

        $display("covered %0d items under %0d timing settings: %0d loads sent, %0d refused",
                 sb.items_taken, settings_done, sb.loads_taken, sb.loads_refused);
        $display("%0d bytes received, %0d results checked, %0d mismatches",
                 sb.rx_bytes, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/tuart_pkg.sv
rtl/tuart_if.sv
rtl/timer_uart_8n1_transceiver_unit.sv
test/testbench.sv
